>>> rtl/core/salc_pkg.sv
// ============================================================================
// salc_pkg
// Shared types, constants and helpers for the set-associative LRU tag cache.
// ============================================================================
`default_nettype none

package salc_pkg;

  localparam int SETS        = 4096;
  localparam int WAYS        = 8;
  localparam int ADDR_W      = 32;
  localparam int USE_W       = 16;
  localparam int TAG_W       = 26;
  localparam int BLOCK_SHIFT = 6;
  localparam int SKIP_SHIFT  = 5;
  localparam int CNT_W       = 16;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  // Divisor width: holds the set count itself.
  localparam int DIV_W = SET_W + 1;

  // Remainder unit retires this many key bits per cycle.
  localparam int REM_BITS  = 2;
  localparam int REM_ITER  = (TAG_W + REM_BITS - 1) / REM_BITS;
  localparam int KEY_PAD_W = REM_ITER * REM_BITS;
  localparam int REM_CNT_W = $clog2(REM_ITER + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LOW    = 1'd1;

  typedef enum logic [1:0] {
    OC_HIT        = 2'd0,
    OC_COMPULSORY = 2'd1,
    OC_CONFLICT   = 2'd2,
    OC_BYPASS     = 2'd3
  } salc_outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_UPDATE
  } salc_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              is_write;
    logic [USE_W-1:0]  use_count;
  } salc_in_t;

  typedef struct packed {
    salc_outcome_t     outcome;
    logic              evicted_dirty;
    logic              dead_on_arrival;
    logic [TAG_W-1:0]  evicted_tag;
    logic [CNT_W-1:0]  dirty_blocks;
    logic [CNT_W-1:0]  peak_dirty_blocks;
  } salc_out_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic             reused;
    logic [TAG_W-1:0] tag;
  } salc_way_t;

  // One memory row holds a whole set: every way plus its recency order,
  // order[0] being the least recently used way.
  typedef struct packed {
    salc_way_t [WAYS-1:0]             ways;
    logic      [WAYS-1:0][WAY_W-1:0]  order;
  } salc_row_t;

  typedef struct packed {
    logic             done;
    logic [SET_W-1:0] set_idx;
  } salc_rem_t;

  function automatic salc_row_t salc_reset_row();
    salc_row_t row;
    row = '0;
    for (int i = 0; i < WAYS; i++) begin
      row.order[i] = WAY_W'(i);
    end
    return row;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/salc_set_rem.sv
// ============================================================================
// salc_set_rem
// Iterative remainder unit: key modulo the set count, a few bits per cycle.
// ============================================================================
`default_nettype none

module salc_set_rem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [salc_pkg::TAG_W-1:0]  key,
  input  wire logic [salc_pkg::DIV_W-1:0]  divisor,
  output salc_pkg::salc_rem_t              result
);
  import salc_pkg::*;

  logic                 active_r;
  logic                 done_r;
  logic [REM_CNT_W-1:0] cnt_r;
  logic [KEY_PAD_W-1:0] key_r;
  logic [KEY_PAD_W-1:0] key_nxt;
  logic [SET_W-1:0]     rem_r;
  logic [SET_W-1:0]     rem_nxt;
  logic [DIV_W-1:0]     div_r;

  // Restoring remainder: the partial remainder stays below the divisor, so
  // one compare and subtract per key bit keeps it in range.
  always_comb begin
    logic [DIV_W-1:0] t;
    rem_nxt = rem_r;
    key_nxt = key_r;
    for (int b = 0; b < REM_BITS; b++) begin
      t = {rem_nxt, key_nxt[KEY_PAD_W-1]};
      if (t >= div_r) begin
        t = t - div_r;
      end
      rem_nxt = t[SET_W-1:0];
      key_nxt = {key_nxt[KEY_PAD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= !start && active_r && (cnt_r == REM_CNT_W'(1));
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= REM_CNT_W'(REM_ITER);
      end else if (active_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == REM_CNT_W'(1)) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= KEY_PAD_W'(key);
      rem_r <= '0;
      div_r <= divisor;
    end else if (active_r) begin
      key_r <= key_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign result.done    = done_r;
  assign result.set_idx = rem_r;

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < div_r))
    else $error("set index not below set count");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("remainder done held more than one cycle");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !active_r)
    else $error("remainder started while still running");

endmodule

`default_nettype wire

>>> rtl/core/set_assoc_lru_cache_tags_top.sv
// ============================================================================
// set_assoc_lru_cache_tags_top
// Tag and LRU policy engine of a write-allocate set-associative cache with
// dirty-block accounting. One memory row per set holds tags, state bits and
// the recency order.
// ============================================================================
//
//   channel  ports                          handshake
//   -------  -----------------------------  --------------------------------
//   input    start, busy, in_data           taken when start && !busy
//   result   out_valid, out_data            one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// After reset the set memory is cleared one row a cycle over all SETS (4096) rows,
// with busy high; configuration writes are taken during that pass.
// A bypassed access returns its word the next cycle, and the next access
// can be taken right away.
// A cached access runs in order: the set index remainder unit retires two
// key bits a cycle, then the row is read, then compared, updated and written
// back. Its word appears the cycle after that.
// The receiver cannot stall; every word is shown for exactly one cycle.
// ============================================================================
`default_nettype none

module set_assoc_lru_cache_tags_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire salc_pkg::salc_in_t               in_data,
  output      logic                             out_valid,
  output      salc_pkg::salc_out_t              out_data,
  input  wire logic                             cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0]       cfg_data
);
  import salc_pkg::*;

  salc_state_t       state_r, state_nxt;
  logic [SET_W-1:0]  clr_cnt_r;
  logic [CFG_W-1:0]  sets_r;
  logic              skip_r;
  salc_in_t          req_r;
  logic [SET_W-1:0]  set_r;
  logic [CNT_W-1:0]  dirty_cnt_r, dirty_cnt_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic              out_valid_r;
  salc_out_t         out_r;
  salc_out_t         byp_out;

  salc_row_t         row_mem [SETS];
  salc_row_t         rd_row_r;
  salc_row_t         wr_row;
  salc_row_t         upd_row;
  logic [SET_W-1:0]  wr_addr;
  logic              mem_we;
  logic              mem_rd;

  logic              accept;
  logic              bypass_in;
  logic              rem_start;
  logic [TAG_W-1:0]  in_tag;
  logic [TAG_W-1:0]  in_key;
  logic [DIV_W-1:0]  set_count;
  salc_rem_t         rem;

  logic [TAG_W-1:0]  req_tag;
  logic [WAYS-1:0]   way_match;
  logic [WAYS-1:0]   pos_match;
  logic [WAYS-1:0]   order_seen;
  logic              hit;
  logic [WAY_W-1:0]  hit_pos;
  logic [WAY_W-1:0]  pos;
  logic [WAY_W-1:0]  way;
  salc_way_t         victim;
  salc_out_t         upd_out;

  // ---------------------------------------------------------------- input
  assign accept    = start && !busy;
  assign bypass_in = (in_data.use_count <= USE_W'(1));
  assign in_tag    = in_data.address[BLOCK_SHIFT +: TAG_W];
  assign in_key    = skip_r ? (in_tag >> SKIP_SHIFT) : in_tag;

  always_comb begin
    if (sets_r == '0) begin
      set_count = DIV_W'(1);
    end else if (int'(sets_r) > SETS) begin
      set_count = DIV_W'(SETS);
    end else begin
      set_count = DIV_W'(sets_r);
    end
  end

  salc_set_rem u_set_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .key     (in_key),
    .divisor (set_count),
    .result  (rem)
  );

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sets_r <= CFG_W'(4096);
      skip_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETS_IN_USE: sets_r <= cfg_data;
        REG_SKIP_LOW:    skip_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_cnt_r == SET_W'(SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept && !bypass_in) state_nxt = ST_DIV;
      ST_DIV:    if (rem.done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    rem_start = 1'b0;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    wr_addr   = set_r;
    wr_row    = upd_row;
    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt_r;
        wr_row  = salc_reset_row();
      end
      ST_IDLE: begin
        busy      = 1'b0;
        rem_start = start && !bypass_in;
      end
      ST_DIV: begin
        mem_rd = rem.done;
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (mem_rd) begin
      set_r <= rem.set_idx;
    end
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_row_r <= row_mem[rem.set_idx];
    end
  end

  // ---------------------------------------------------------------- lookup
  assign req_tag = req_r.address[BLOCK_SHIFT +: TAG_W];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_match[w] = rd_row_r.ways[w].valid && (rd_row_r.ways[w].tag == req_tag);
    end
    order_seen = '0;
    for (int p = 0; p < WAYS; p++) begin
      pos_match[p]                  = way_match[rd_row_r.order[p]];
      order_seen[rd_row_r.order[p]] = 1'b1;
    end
    // The first match walking from the least recently used end wins.
    hit_pos = '0;
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (pos_match[p]) begin
        hit_pos = WAY_W'(p);
      end
    end
  end

  assign hit    = |pos_match;
  assign pos    = hit ? hit_pos : '0;
  assign way    = rd_row_r.order[pos];
  assign victim = rd_row_r.ways[way];

  always_comb begin
    logic [CNT_W-1:0] cnt;
    cnt     = dirty_cnt_r;
    upd_row = rd_row_r;
    upd_out = '0;

    // Move the touched way to the most recently used end.
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) < pos) begin
        upd_row.order[i] = rd_row_r.order[i];
      end else if (i == WAYS - 1) begin
        upd_row.order[i] = way;
      end else begin
        upd_row.order[i] = rd_row_r.order[(i < WAYS - 1) ? i + 1 : i];
      end
    end

    if (hit) begin
      upd_out.outcome = OC_HIT;
      if (req_r.is_write && !victim.dirty && cnt != CNT_MAX) begin
        cnt = cnt + 1'b1;
      end
      upd_row.ways[way].dirty  = victim.dirty || req_r.is_write;
      upd_row.ways[way].reused = 1'b1;
    end else begin
      if (!victim.valid) begin
        upd_out.outcome = OC_COMPULSORY;
      end else begin
        upd_out.outcome         = OC_CONFLICT;
        upd_out.evicted_tag     = victim.tag;
        upd_out.dead_on_arrival = !victim.reused;
      end
      if (req_r.is_write && cnt != CNT_MAX) begin
        cnt = cnt + 1'b1;
      end
      if (victim.dirty) begin
        upd_out.evicted_dirty = 1'b1;
        if (cnt != '0) begin
          cnt = cnt - 1'b1;
        end
      end
      upd_row.ways[way].valid  = 1'b1;
      upd_row.ways[way].dirty  = req_r.is_write;
      upd_row.ways[way].reused = 1'b0;
      upd_row.ways[way].tag    = req_tag;
    end

    dirty_cnt_nxt             = cnt;
    peak_nxt                  = (cnt > peak_r) ? cnt : peak_r;
    upd_out.dirty_blocks      = dirty_cnt_nxt;
    upd_out.peak_dirty_blocks = peak_nxt;
  end

  // A bypassed access reports the counts as they stand.
  always_comb begin
    byp_out                   = '0;
    byp_out.outcome           = OC_BYPASS;
    byp_out.dirty_blocks      = dirty_cnt_r;
    byp_out.peak_dirty_blocks = peak_r;
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_cnt_r <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_UPDATE) || (accept && bypass_in);
      if (state_r == ST_UPDATE) begin
        dirty_cnt_r <= dirty_cnt_nxt;
        peak_r      <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      out_r <= upd_out;
    end else if (accept && bypass_in) begin
      out_r <= byp_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= dirty_cnt_r)
    else $error("peak dirty count below running count");

  a_order_perm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> (order_seen == '1))
    else $error("set recency order is not a permutation of the ways");

  a_update_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> out_valid_r)
    else $error("cached access finished without a result word");

  a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem.done |-> (state_r == ST_DIV))
    else $error("set index ready outside the index phase");

endmodule

`default_nettype wire

>>> dv/tb_set_assoc_lru_cache_tags_top.sv
// ============================================================================
// tb_set_assoc_lru_cache_tags_top
// Self-checking bench for the set-associative LRU tag engine. A behavioral
// copy of the cache tags, recency order and dirty accounting predicts every
// result word. Directed accesses cover bypass, hit, compulsory and conflict
// misses. Random phases then run under several set counts and index modes,
// including the range extremes, with random input gaps but for a final streaming phase.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb_set_assoc_lru_cache_tags_top;
  import salc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int MAX_REPORTS    = 100;
  localparam int HOT_TAGS       = 30;
  localparam int EXP_DEPTH      = 64;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  salc_in_t             in_data;
  logic                 out_valid;
  salc_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  set_assoc_lru_cache_tags_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Behavioral copy of the tag store and its policy state.
  bit [TAG_W-1:0] tag_store  [SETS][WAYS];
  bit             way_valid  [SETS][WAYS];
  bit             way_dirty  [SETS][WAYS];
  bit             way_reused [SETS][WAYS];
  int unsigned    recency    [SETS][WAYS];
  int unsigned    dirty_total;
  int unsigned    dirty_peak;
  int unsigned    sets_reg;
  bit             skip_reg;

  // Ring of predicted words, filled at acceptance and emptied by the checker.
  salc_out_t      expected_words [EXP_DEPTH];
  int unsigned    exp_wr_cnt;
  int unsigned    exp_rd_cnt;
  int unsigned    hot_tags [HOT_TAGS];
  int             mismatches;
  bit             idle_on;
  int             idle_pct;
  int             stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_cache_model();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_store[s][w]  = '0;
        way_valid[s][w]  = 1'b0;
        way_dirty[s][w]  = 1'b0;
        way_reused[s][w] = 1'b0;
        recency[s][w]    = w;
      end
    end
    dirty_total = 0;
    dirty_peak  = 0;
    sets_reg    = 4096;
    skip_reg    = 1'b0;
  endfunction

  function automatic int unsigned effective_sets();
    int unsigned n;
    n = sets_reg;
    if (n == 0) n = 1;
    if (n > SETS) n = SETS;
    return n;
  endfunction

  function automatic void record_expected(salc_out_t w);
    expected_words[exp_wr_cnt % EXP_DEPTH] = w;
    exp_wr_cnt = exp_wr_cnt + 1;
  endfunction

  // Moves the way at recency position pos to the most recently used slot.
  function automatic void promote_way(int unsigned set_idx, int pos);
    int unsigned w;
    w = recency[set_idx][pos];
    for (int i = pos; i < WAYS - 1; i++) recency[set_idx][i] = recency[set_idx][i + 1];
    recency[set_idx][WAYS - 1] = w;
  endfunction

  function automatic salc_out_t predict_access(salc_in_t acc);
    salc_out_t    r;
    bit [TAG_W-1:0] tag;
    int unsigned  key;
    int unsigned  set_idx;
    int unsigned  w;
    int           pos;
    bit           hit;
    r = '0;
    r.outcome = OC_BYPASS;
    if (acc.use_count > 1) begin
      tag = acc.address[ADDR_W-1:BLOCK_SHIFT];
      key = skip_reg ? (tag >> SKIP_SHIFT) : tag;
      set_idx = key % effective_sets();
      hit = 1'b0;
      w = 0;
      for (pos = 0; pos < WAYS; pos++) begin
        w = recency[set_idx][pos];
        if (way_valid[set_idx][w] && tag_store[set_idx][w] == tag) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        r.outcome = OC_HIT;
        if (acc.is_write && !way_dirty[set_idx][w]) begin
          way_dirty[set_idx][w] = 1'b1;
          if (dirty_total < 65535) dirty_total++;
        end
        way_reused[set_idx][w] = 1'b1;
        promote_way(set_idx, pos);
      end else begin
        w = recency[set_idx][0];
        if (!way_valid[set_idx][w]) begin
          r.outcome = OC_COMPULSORY;
        end else begin
          r.outcome = OC_CONFLICT;
          r.evicted_tag = tag_store[set_idx][w];
          r.dead_on_arrival = !way_reused[set_idx][w];
        end
        if (acc.is_write && dirty_total < 65535) dirty_total++;
        if (way_dirty[set_idx][w]) begin
          r.evicted_dirty = 1'b1;
          if (dirty_total > 0) dirty_total--;
        end
        tag_store[set_idx][w]  = tag;
        way_valid[set_idx][w]  = 1'b1;
        way_dirty[set_idx][w]  = acc.is_write;
        way_reused[set_idx][w] = 1'b0;
        promote_way(set_idx, 0);
      end
      if (dirty_total > dirty_peak) dirty_peak = dirty_total;
    end
    r.dirty_blocks      = CNT_W'(dirty_total);
    r.peak_dirty_blocks = CNT_W'(dirty_peak);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, got_val);
    end
  endfunction

  // Result checker: the block cannot be stalled, so every strobe is a word.
  always @(posedge clk) begin
    salc_out_t exp_word;
    if (rst_n && out_valid) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none actual %0h", $time, out_data);
      end else begin
        exp_word   = expected_words[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt = exp_rd_cnt + 1;
        check_field("outcome", exp_word.outcome, out_data.outcome);
        check_field("evicted_dirty", exp_word.evicted_dirty, out_data.evicted_dirty);
        check_field("dead_on_arrival", exp_word.dead_on_arrival, out_data.dead_on_arrival);
        check_field("evicted_tag", exp_word.evicted_tag, out_data.evicted_tag);
        check_field("dirty_blocks", exp_word.dirty_blocks, out_data.dirty_blocks);
        check_field("peak_dirty_blocks", exp_word.peak_dirty_blocks,
                    out_data.peak_dirty_blocks);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Start stays high after acceptance; the caller either sends the next word
  // in the same step or lowers start through a gap or a drain.
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr,
                             input logic [USE_W-1:0] uses);
    salc_in_t acc;
    acc.address   = addr;
    acc.is_write  = wr;
    acc.use_count = uses;
    in_data <= acc;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    record_expected(predict_access(acc));
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned sets_val, input bit skip_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SETS_IN_USE;
    cfg_data  <= CFG_W'(sets_val);
    @(posedge clk);
    cfg_index <= REG_SKIP_LOW;
    cfg_data  <= CFG_W'(skip_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    sets_reg = sets_val & 32'h1FFF;
    skip_reg = skip_val;
  endtask

  // Builds tags that pile onto three sets so that hits and evictions are common.
  task automatic build_hot_tags();
    int unsigned n;
    int unsigned key_span;
    int unsigned targets[3];
    int unsigned key;
    int unsigned tag;
    n = effective_sets();
    key_span = skip_reg ? (1 << (TAG_W - SKIP_SHIFT)) : (1 << TAG_W);
    for (int i = 0; i < 3; i++) targets[i] = $urandom_range(0, n - 1);
    for (int i = 0; i < HOT_TAGS; i++) begin
      key = targets[i % 3] + n * $urandom_range(0, key_span / n - 1);
      tag = skip_reg ? ((key << SKIP_SHIFT) | $urandom_range(0, 31)) : key;
      hot_tags[i] = tag & ((1 << TAG_W) - 1);
    end
  endtask

  task automatic run_random_phase(input int unsigned sets_val, input bit skip_val,
                                  input int count);
    logic [ADDR_W-1:0] addr;
    logic [USE_W-1:0]  uses;
    drain_results();
    set_config(sets_val, skip_val);
    build_hot_tags();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85)
        addr = {TAG_W'(hot_tags[$urandom_range(0, HOT_TAGS - 1)]), 6'($urandom)};
      else
        addr = $urandom;
      if ($urandom_range(0, 99) < 12)
        uses = USE_W'($urandom_range(0, 1));
      else
        uses = USE_W'($urandom_range(2, 65535));
      send_access(addr, 1'($urandom_range(0, 1)), uses);
    end
  endtask

  // Reset values of the registers: 4096 sets, full tag indexing.
  task automatic test_directed();
    logic [TAG_W-1:0] t;
    send_access(32'hFFFF_FFFF, 1'b0, 16'd0);
    send_access(32'h0000_0000, 1'b1, 16'd1);
    send_access(32'h0000_0000, 1'b0, 16'd2);
    send_access(32'h0000_003F, 1'b0, 16'hFFFF);
    send_access(32'h0000_0010, 1'b1, 16'd2);
    send_access(32'h0000_0020, 1'b1, 16'd3);
    send_access(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    // Ten tags in one set: the ninth evicts a dirty reused block, the tenth
    // a block that never hit.
    for (int k = 0; k < 10; k++) begin
      t = TAG_W'(5 + 4096 * k);
      send_access({t, 6'd0}, (k == 0 || k == 9), 16'd4);
      if (k == 0) send_access({t, 6'h2A}, 1'b0, 16'd4);
    end
  endtask

  task automatic test_set_count_extremes();
    run_random_phase(0, 1'b0, 120);
    run_random_phase(1, 1'b1, 120);
    run_random_phase(8191, 1'b0, 120);
  endtask

  task automatic test_skip_low_bits();
    run_random_phase(4096, 1'b1, 120);
    run_random_phase(4097, 1'b1, 120);
  endtask

  task automatic test_random_configs();
    run_random_phase(5, 1'b0, 100);
    run_random_phase(37, 1'b1, 100);
    run_random_phase(4095, 1'b0, 100);
    run_random_phase($urandom_range(0, 8191), 1'($urandom_range(0, 1)), 100);
  endtask

  // Back-to-back traffic with no input gaps.
  task automatic test_streaming();
    idle_on = 1'b0;
    run_random_phase(2048, 1'b0, 200);
  endtask

  initial begin
    mismatches   = 0;
    stall_cycles = 0;
    exp_wr_cnt   = 0;
    exp_rd_cnt   = 0;
    idle_on      = 1'b1;
    idle_pct     = 30;
    clear_cache_model();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_set_count_extremes();
    idle_pct = 60;
    test_skip_low_bits();
    idle_pct = 15;
    test_random_configs();
    test_streaming();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
